>>> design/gdc_pkg.sv
// shared constants of the grid ray caster
package gdc_pkg;

	localparam int PosW   = 22;
	localparam int DirW   = 16;
	localparam int DeltaW = 24;
	localparam int DistW  = 32;
	localparam int FracW  = 16;
	localparam int CellW  = 6;
	localparam int StatW  = 2;

	localparam logic       OP_WRITE = 1'b0;
	localparam logic       OP_CAST  = 1'b1;

	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_LEFT  = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	localparam logic       REG_PLAYER_X = 1'b0;
	localparam logic       REG_PLAYER_Y = 1'b1;

endpackage

>>> design/grid_ray_dda_caster_top.sv
// grid ray caster: wall map memory and dda walk sequencer
//
// Command channel: a word is taken when start is high and busy is low.
// opcode write stores is_wall at (cell_x, cell_y) in that cycle and the
// block stays ready; no result follows. opcode cast walks the map from the
// player's cell and returns one result word, shown for one cycle with done.
// Player position is set through cfg_we / cfg_idx / cfg_data while idle, a
// rule on the user that the block does not enforce. A cast runs S_INIT to set
// up, S_STEP and S_CHECK per map cell walked (one registered wall map read
// each), then S_DIST, S_MUL, S_DONE for distance and wall fraction;
// a cast that stops early on the map edge or the step limit skips that tail.
// At most MAX_STEPS cells are walked. After reset the wall map is cleared one
// cell per cycle, all MAP_SIZE*MAP_SIZE cells, with busy high; config writes
// are still taken. The receiver cannot stall: done is a one-cycle strobe.
module grid_ray_dda_caster_top #(
	parameter int MAP_SIZE  = 64,
	parameter int MAX_STEPS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [gdc_pkg::PosW-1:0]      cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [gdc_pkg::CellW-1:0]     cell_x,
	input  logic [gdc_pkg::CellW-1:0]     cell_y,
	input  logic                          is_wall,
	input  logic signed [gdc_pkg::DirW-1:0] dir_x,
	input  logic signed [gdc_pkg::DirW-1:0] dir_y,
	input  logic [gdc_pkg::DeltaW-1:0]    delta_x,
	input  logic [gdc_pkg::DeltaW-1:0]    delta_y,
	output logic                          done,
	output logic [gdc_pkg::DistW-1:0]     perp_len,
	output logic                          hit_side,
	output logic [gdc_pkg::FracW-1:0]     wall_frac,
	output logic [gdc_pkg::CellW-1:0]     hit_x,
	output logic [gdc_pkg::CellW-1:0]     hit_y,
	output logic [gdc_pkg::StatW-1:0]     status
);

	localparam int CW    = $clog2(MAP_SIZE);
	localparam int WW    = ((CW > gdc_pkg::CellW) ? CW : gdc_pkg::CellW) + 2;
	localparam int DEPTH = MAP_SIZE * MAP_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int SCW   = $clog2(MAX_STEPS + 1);
	localparam int DW    = gdc_pkg::DistW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_INIT  = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DIST  = 3'd5;
	localparam logic [2:0] S_MUL   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]                 state_q;
	logic [AW-1:0]              clr_q;
	logic [gdc_pkg::PosW-1:0]   px_q, py_q;
	logic signed [gdc_pkg::DirW-1:0] dx_q, dy_q;
	logic [gdc_pkg::DeltaW-1:0] delx_q, dely_q;
	logic [DW-1:0]              sdx_q, sdy_q, dist_q;
	logic signed [WW-1:0]       mx_q, my_q;
	logic [SCW-1:0]             cnt_q;
	logic                       side_q;
	logic [29:0]                prod_q;
	logic                       rd_q;
	logic                       mem [DEPTH];

	logic                       acc;
	logic                       mem_we, mem_wd;
	logic [AW-1:0]              waddr, raddr;
	logic [DW-1:0]              ddx, ddy, dcur, scur;
	logic [DW:0]                sumx, sumy;
	logic                       adv_x;
	logic signed [WW-1:0]       nx, ny;
	logic                       out_map;
	logic signed [gdc_pkg::DirW-1:0] dsel;
	logic [47:0]                prod;
	logic [gdc_pkg::FracW-1:0]  frac_raw, frac_fin;
	logic                       mirror;
	logic [40:0]                mulx, muly;
	logic [16:0]                fxa, fya;

	assign busy = (state_q != S_IDLE);
	assign acc  = start && !busy;

	assign ddx  = DW'({delx_q, 2'b00});
	assign ddy  = DW'({dely_q, 2'b00});
	assign sumx = {1'b0, sdx_q} + {1'b0, ddx};
	assign sumy = {1'b0, sdy_q} + {1'b0, ddy};
	assign adv_x = sdx_q < sdy_q;
	assign nx = adv_x ? (dx_q < 0 ? mx_q - WW'(1) : mx_q + WW'(1)) : mx_q;
	assign ny = adv_x ? my_q : (dy_q < 0 ? my_q + WW'(1) : my_q - WW'(1));
	assign out_map = (nx < 0) || (ny < 0) || (nx >= WW'(MAP_SIZE)) || (ny >= WW'(MAP_SIZE));
	assign raddr = AW'(ny[CW-1:0] * MAP_SIZE) + AW'(nx[CW-1:0]);

	assign fxa  = (dx_q < 0) ? {1'b0, px_q[15:0]} : 17'h10000 - {1'b0, px_q[15:0]};
	assign fya  = (dy_q < 0) ? 17'h10000 - {1'b0, py_q[15:0]} : {1'b0, py_q[15:0]};
	assign mulx = fxa * delx_q;
	assign muly = fya * dely_q;

	assign dcur = side_q ? ddy : ddx;
	assign scur = side_q ? sdy_q : sdx_q;
	assign dsel = side_q ? dx_q : dy_q;
	assign prod = $signed({1'b0, dist_q}) * dsel;
	assign frac_raw = (side_q ? px_q[15:0] : py_q[15:0]) + prod_q[29:14];
	assign mirror = (!side_q && dx_q > 0) || (side_q && dy_q < 0);
	assign frac_fin = mirror ? ((frac_raw == '0) ? '1 : (~frac_raw + 16'd1)) : frac_raw;

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wd = 1'b0;
			waddr  = clr_q;
		end else begin
			mem_we = acc && (opcode == gdc_pkg::OP_WRITE)
				&& (32'(cell_x) < MAP_SIZE) && (32'(cell_y) < MAP_SIZE);
			mem_wd = is_wall;
			waddr  = AW'(32'(cell_y) * MAP_SIZE + 32'(cell_x));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= mem_wd;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gdc_pkg::REG_PLAYER_X: px_q <= cfg_data;
				gdc_pkg::REG_PLAYER_Y: py_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && opcode == gdc_pkg::OP_CAST) begin
			dx_q   <= dir_x;
			dy_q   <= dir_y;
			delx_q <= delta_x;
			dely_q <= delta_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			done      <= 1'b0;
			sdx_q     <= '0;
			sdy_q     <= '0;
			mx_q      <= '0;
			my_q      <= '0;
			cnt_q     <= '0;
			side_q    <= 1'b0;
			dist_q    <= '0;
			prod_q    <= '0;
			perp_len  <= '0;
			hit_side  <= 1'b0;
			wall_frac <= '0;
			hit_x     <= '0;
			hit_y     <= '0;
			status    <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc && opcode == gdc_pkg::OP_CAST) begin
						mx_q    <= WW'(px_q[21:16]);
						my_q    <= WW'(py_q[21:16]);
						cnt_q   <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					sdx_q <= DW'(mulx >> 14);
					sdy_q <= DW'(muly >> 14);
					if (mx_q >= WW'(MAP_SIZE) || my_q >= WW'(MAP_SIZE)) begin
						perp_len  <= '0;
						hit_side  <= 1'b0;
						wall_frac <= '0;
						hit_x     <= '0;
						hit_y     <= '0;
						status    <= gdc_pkg::ST_LEFT;
						done      <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (adv_x) begin
						sdx_q  <= sumx[DW] ? '1 : sumx[DW-1:0];
						side_q <= 1'b0;
					end else begin
						sdy_q  <= sumy[DW] ? '1 : sumy[DW-1:0];
						side_q <= 1'b1;
					end
					mx_q  <= nx;
					my_q  <= ny;
					cnt_q <= cnt_q + SCW'(1);
					if (out_map) begin
						perp_len  <= '0;
						hit_side  <= 1'b0;
						wall_frac <= '0;
						hit_x     <= '0;
						hit_y     <= '0;
						status    <= gdc_pkg::ST_LEFT;
						done      <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (rd_q) begin
						state_q <= S_DIST;
					end else if (cnt_q == SCW'(MAX_STEPS)) begin
						perp_len  <= '0;
						hit_side  <= 1'b0;
						wall_frac <= '0;
						hit_x     <= '0;
						hit_y     <= '0;
						status    <= gdc_pkg::ST_LIMIT;
						done      <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DIST: begin
					dist_q  <= (scur > dcur) ? scur - dcur : '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= prod[29:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					perp_len  <= dist_q;
					hit_side  <= side_q;
					wall_frac <= frac_fin;
					hit_x     <= mx_q[gdc_pkg::CellW-1:0];
					hit_y     <= my_q[gdc_pkg::CellW-1:0];
					status    <= gdc_pkg::ST_HIT;
					done      <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/gdc_checker.sv
// port checker for the grid ray caster and its bind
module gdc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        opcode,
	input logic                        done,
	input logic [gdc_pkg::DistW-1:0]   perp_len,
	input logic                        hit_side,
	input logic [gdc_pkg::FracW-1:0]   wall_frac,
	input logic [gdc_pkg::CellW-1:0]   hit_x,
	input logic [gdc_pkg::CellW-1:0]   hit_y,
	input logic [gdc_pkg::StatW-1:0]   status
);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != gdc_pkg::ST_HIT |-> perp_len == '0 && !hit_side
			&& wall_frac == '0 && hit_x == '0 && hit_y == '0)
		else $error("error word carries nonzero fields");

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == gdc_pkg::OP_CAST |=> busy)
		else $error("cast word not followed by busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == gdc_pkg::OP_WRITE |=> !busy && !done)
		else $error("map write caused activity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result word outside end of cast");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind grid_ray_dda_caster_top gdc_checker u_gdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.opcode    (opcode),
	.done      (done),
	.perp_len  (perp_len),
	.hit_side  (hit_side),
	.wall_frac (wall_frac),
	.hit_x     (hit_x),
	.hit_y     (hit_y),
	.status    (status)
);
